// ===== rtl/core/pss_pkg.sv =====
// Shared constants, types and codes for the path sanitizer and splitter.
`timescale 1ns / 1ps

package pss_pkg;

    localparam int PATH_LIMIT       = 128;
    localparam int NAME_LIMIT       = 32;
    localparam int MOUNTS           = 2;
    localparam int MOUNT_NAME_BYTES = 8;

    localparam int CLEN_W   = $clog2(NAME_LIMIT + 1);
    localparam int BADDR_W  = $clog2(NAME_LIMIT);
    localparam int TLEN_W   = $clog2(PATH_LIMIT + 1);
    localparam int MSEL_W   = (MOUNTS > 1) ? $clog2(MOUNTS) : 1;
    localparam int MCNT_W   = 2;
    localparam int MLEN_W   = 4;
    localparam int MNB_W    = (MOUNT_NAME_BYTES > 1) ? $clog2(MOUNT_NAME_BYTES) : 1;
    localparam int DATA_W   = 64;
    localparam int REG_COUNT = 5;
    localparam int PADDR_W  = $clog2(8 * REG_COUNT);

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [1:0] NO_MOUNT  = 2'd3;
    localparam logic [1:0] ROOT_IDX  = 2'b11;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ARG      = 2'd1,
        STAT_TOOBIG   = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_MOUNT0_NAME = 3'd0,
        REG_MOUNT0_LEN  = 3'd1,
        REG_MOUNT1_NAME = 3'd2,
        REG_MOUNT1_LEN  = 3'd3,
        REG_MOUNT_COUNT = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_MNT,
        S_CMP_RD,
        S_CMP_CHK,
        S_SEP,
        S_EMIT_RD,
        S_EMIT_PUT,
        S_STATUS
    } state_t;

    typedef struct packed {
        logic [MOUNTS-1:0][DATA_W-1:0] mount_name;
        logic [MOUNTS-1:0][MLEN_W-1:0] mount_len;
        logic [MCNT_W-1:0]             mount_count;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic        is_status;
        logic [7:0]  rel_byte;
        status_t     status;
        logic [1:0]  mount_index;
        logic        last;
    } emit_t;

endpackage

// ===== rtl/core/pss_cfg.sv =====
// APB-style configuration registers holding the mount table.
`timescale 1ns / 1ps

module pss_cfg
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [DATA_W-1:0] mount0_name_reg, mount1_name_reg;
    logic [MLEN_W-1:0] mount0_len_reg, mount1_len_reg;
    logic [MCNT_W-1:0] mount_count_reg;
    reg_idx_t          sel_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign sel_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mount0_name_reg <= DATA_W'(64'd7630441);
            mount0_len_reg  <= MLEN_W'(3);
            mount1_name_reg <= DATA_W'(64'd25715);
            mount1_len_reg  <= MLEN_W'(2);
            mount_count_reg <= MCNT_W'(2);
        end
        else if (wr_en)
        begin
            unique case (sel_idx)
                REG_MOUNT0_NAME: mount0_name_reg <= pwdata;
                REG_MOUNT0_LEN:  mount0_len_reg  <= pwdata[MLEN_W-1:0];
                REG_MOUNT1_NAME: mount1_name_reg <= pwdata;
                REG_MOUNT1_LEN:  mount1_len_reg  <= pwdata[MLEN_W-1:0];
                REG_MOUNT_COUNT: mount_count_reg <= pwdata[MCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel_idx)
            REG_MOUNT0_NAME: prdata = mount0_name_reg;
            REG_MOUNT0_LEN:  prdata = DATA_W'(mount0_len_reg);
            REG_MOUNT1_NAME: prdata = mount1_name_reg;
            REG_MOUNT1_LEN:  prdata = DATA_W'(mount1_len_reg);
            REG_MOUNT_COUNT: prdata = DATA_W'(mount_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.mount_name  = {mount1_name_reg, mount0_name_reg};
    assign cfg.mount_len   = {mount1_len_reg, mount0_len_reg};
    assign cfg.mount_count = mount_count_reg;

endmodule

// ===== rtl/core/pss_cbuf.sv =====
// Component buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module pss_cbuf
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [BADDR_W-1:0] wr_addr,
    input  logic [7:0]         wr_data,
    input  logic [BADDR_W-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [NAME_LIMIT];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/pss_ctrl.sv =====
// Sequencer: takes path bytes, checks components, matches mounts and emits words.
`timescale 1ns / 1ps

module pss_ctrl
    import pss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] path_byte,
    input  logic       end_of_path,
    input  cfg_t       cfg,
    input  logic       out_free,
    output emit_t      emit
);

    state_t              state_reg, state_next;
    logic [CLEN_W-1:0]   comp_len_reg, comp_len_next;
    logic [TLEN_W-1:0]   total_reg, total_next;
    logic                at_first_reg, at_first_next;
    logic                start_bad_reg, start_bad_next;
    status_t             first_err_reg, first_err_next;
    logic [1:0]          found_reg, found_next;
    logic                bad_reg, bad_next;
    logic                rem_started_reg, rem_started_next;
    logic                dot0_reg, dot0_next;
    logic                dot1_reg, dot1_next;
    logic                end_reg, end_next;
    logic [BADDR_W-1:0]  idx_reg, idx_next;
    logic [MSEL_W-1:0]   m_reg, m_next;

    logic                wr_en;
    logic [7:0]          rd_data;
    logic                is_slash;
    logic                skip, reject, go_mnt, go_emit;
    logic                dot_only, dot_dot;
    logic [MLEN_W-1:0]   len_raw, len_eff;
    logic [MCNT_W-1:0]   cnt_eff;
    logic                m_try, m_last;
    logic [DATA_W-1:0]   name_sel;
    logic [7:0]          name_byte;
    logic                byte_eq;
    logic                cmp_at_end, emit_at_end;
    logic                comp_end;
    state_t              done_state;
    status_t             code;

    pss_cbuf u_cbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (comp_len_reg[BADDR_W-1:0]),
        .wr_data (path_byte),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign is_slash = (path_byte == CH_SLASH);

    // Component classification
    assign skip     = (comp_len_reg == '0) || start_bad_reg || (first_err_reg != STAT_OK);
    assign dot_only = (comp_len_reg == CLEN_W'(1)) && dot0_reg;
    assign dot_dot  = (comp_len_reg == CLEN_W'(2)) && dot0_reg && dot1_reg;
    assign reject   = (comp_len_reg == CLEN_W'(NAME_LIMIT)) || bad_reg || dot_dot;
    assign go_mnt   = !skip && !reject && !dot_only && (found_reg == NO_MOUNT);
    assign go_emit  = !skip && !reject && !dot_only && (found_reg != NO_MOUNT)
                      && (total_reg < TLEN_W'(PATH_LIMIT));

    // Mount table view for the current candidate
    assign len_raw  = cfg.mount_len[m_reg];
    assign len_eff  = (len_raw > MLEN_W'(MOUNT_NAME_BYTES)) ?
                      MLEN_W'(MOUNT_NAME_BYTES) : len_raw;
    assign cnt_eff  = (cfg.mount_count > MCNT_W'(MOUNTS)) ?
                      MCNT_W'(MOUNTS) : cfg.mount_count;
    assign m_try    = (MCNT_W'(m_reg) < cnt_eff) && (len_eff != '0)
                      && (comp_len_reg == CLEN_W'(len_eff));
    assign m_last   = (m_reg == MSEL_W'(MOUNTS - 1));
    assign name_sel = cfg.mount_name[m_reg];
    assign name_byte = name_sel[{idx_reg[MNB_W-1:0], 3'b000} +: 8];

    // Shared byte comparator
    assign byte_eq     = (rd_data == name_byte);
    assign cmp_at_end  = ((CLEN_W'(idx_reg) + CLEN_W'(1)) == CLEN_W'(len_eff));
    assign emit_at_end = ((CLEN_W'(idx_reg) + CLEN_W'(1)) == comp_len_reg);

    assign done_state = end_reg ? S_STATUS : S_IDLE;

    always_comb
    begin
        if (start_bad_reg)
        begin
            code = STAT_ARG;
        end
        else if (total_reg >= TLEN_W'(PATH_LIMIT))
        begin
            code = STAT_TOOBIG;
        end
        else
        begin
            code = first_err_reg;
        end
    end

    always_comb
    begin
        comp_end = 1'b0;
        unique case (state_reg)
            S_FIN:      comp_end = !go_mnt && !go_emit;
            S_MNT:      comp_end = !m_try && m_last;
            S_CMP_CHK:  comp_end = byte_eq ? cmp_at_end : m_last;
            S_EMIT_PUT: comp_end = out_free && emit_at_end;
            default:    comp_end = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (is_slash || end_of_path) ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (go_mnt)
                begin
                    state_next = S_MNT;
                end
                else if (go_emit)
                begin
                    state_next = rem_started_reg ? S_SEP : S_EMIT_RD;
                end
                else
                begin
                    state_next = done_state;
                end
            end
            S_MNT:
            begin
                if (m_try)
                begin
                    state_next = S_CMP_RD;
                end
                else if (m_last)
                begin
                    state_next = done_state;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (comp_end)
                begin
                    state_next = done_state;
                end
                else if (byte_eq)
                begin
                    state_next = S_CMP_RD;
                end
                else
                begin
                    state_next = S_MNT;
                end
            end
            S_SEP:
            begin
                if (out_free)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_PUT;
            end
            S_EMIT_PUT:
            begin
                if (out_free)
                begin
                    state_next = emit_at_end ? done_state : S_EMIT_RD;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        comp_len_next    = comp_len_reg;
        total_next       = total_reg;
        at_first_next    = at_first_reg;
        start_bad_next   = start_bad_reg;
        first_err_next   = first_err_reg;
        found_next       = found_reg;
        bad_next         = bad_reg;
        rem_started_next = rem_started_reg;
        dot0_next        = dot0_reg;
        dot1_next        = dot1_reg;
        end_next         = end_reg;
        idx_next         = idx_reg;
        m_next           = m_reg;
        wr_en            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    end_next      = end_of_path;
                    at_first_next = 1'b0;
                    if (at_first_reg && !is_slash)
                    begin
                        start_bad_next = 1'b1;
                    end
                    if (total_reg < TLEN_W'(PATH_LIMIT))
                    begin
                        total_next = total_reg + TLEN_W'(1);
                    end
                    if (!is_slash)
                    begin
                        if ((path_byte < CH_SPACE) || (path_byte == CH_DEL)
                            || (path_byte == CH_BSLASH))
                        begin
                            bad_next = 1'b1;
                        end
                        if (comp_len_reg < CLEN_W'(NAME_LIMIT))
                        begin
                            wr_en         = 1'b1;
                            comp_len_next = comp_len_reg + CLEN_W'(1);
                            if (comp_len_reg == CLEN_W'(0))
                            begin
                                dot0_next = (path_byte == CH_DOT);
                            end
                            if (comp_len_reg == CLEN_W'(1))
                            begin
                                dot1_next = (path_byte == CH_DOT);
                            end
                        end
                    end
                end
            end
            S_FIN:
            begin
                idx_next = '0;
                m_next   = '0;
                if (!skip)
                begin
                    priority if (comp_len_reg == CLEN_W'(NAME_LIMIT))
                    begin
                        first_err_next = STAT_TOOBIG;
                    end
                    else if (bad_reg || dot_dot)
                    begin
                        first_err_next = STAT_ARG;
                    end
                    else if (go_emit)
                    begin
                        rem_started_next = 1'b1;
                    end
                end
            end
            S_MNT:
            begin
                idx_next = '0;
                if (!m_try)
                begin
                    if (m_last)
                    begin
                        first_err_next = STAT_NOTFOUND;
                    end
                    else
                    begin
                        m_next = m_reg + MSEL_W'(1);
                    end
                end
            end
            S_CMP_CHK:
            begin
                if (byte_eq)
                begin
                    if (cmp_at_end)
                    begin
                        found_next = 2'(m_reg);
                    end
                    else
                    begin
                        idx_next = idx_reg + BADDR_W'(1);
                    end
                end
                else if (m_last)
                begin
                    first_err_next = STAT_NOTFOUND;
                end
                else
                begin
                    m_next = m_reg + MSEL_W'(1);
                end
            end
            S_EMIT_PUT:
            begin
                if (out_free && !emit_at_end)
                begin
                    idx_next = idx_reg + BADDR_W'(1);
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    total_next       = '0;
                    at_first_next    = 1'b1;
                    start_bad_next   = 1'b0;
                    first_err_next   = STAT_OK;
                    found_next       = NO_MOUNT;
                    rem_started_next = 1'b0;
                end
            end
            default: ;
        endcase

        // Drop the finished component
        if (comp_end)
        begin
            comp_len_next = '0;
            bad_next      = 1'b0;
            dot0_next     = 1'b0;
            dot1_next     = 1'b0;
        end
    end

    // Result words
    always_comb
    begin
        emit = '0;
        unique case (state_reg)
            S_SEP:
            begin
                emit.valid    = 1'b1;
                emit.rel_byte = CH_SLASH;
            end
            S_EMIT_PUT:
            begin
                emit.valid    = 1'b1;
                emit.rel_byte = rd_data;
                emit.last     = emit_at_end && !end_reg;
            end
            S_STATUS:
            begin
                emit.valid       = 1'b1;
                emit.is_status   = 1'b1;
                emit.status      = code;
                emit.mount_index = ((code == STAT_OK) && (found_reg != NO_MOUNT)) ?
                                   found_reg : ROOT_IDX;
                emit.last        = 1'b1;
            end
            default: emit = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            comp_len_reg    <= '0;
            total_reg       <= '0;
            at_first_reg    <= 1'b1;
            start_bad_reg   <= 1'b0;
            first_err_reg   <= STAT_OK;
            found_reg       <= NO_MOUNT;
            bad_reg         <= 1'b0;
            rem_started_reg <= 1'b0;
            dot0_reg        <= 1'b0;
            dot1_reg        <= 1'b0;
            end_reg         <= 1'b0;
            idx_reg         <= '0;
            m_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            comp_len_reg    <= comp_len_next;
            total_reg       <= total_next;
            at_first_reg    <= at_first_next;
            start_bad_reg   <= start_bad_next;
            first_err_reg   <= first_err_next;
            found_reg       <= found_next;
            bad_reg         <= bad_next;
            rem_started_reg <= rem_started_next;
            dot0_reg        <= dot0_next;
            dot1_reg        <= dot1_next;
            end_reg         <= end_next;
            idx_reg         <= idx_next;
            m_reg           <= m_next;
        end
    end

`ifndef ASSERT_OFF
    a_comp_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        comp_len_reg <= CLEN_W'(NAME_LIMIT))
        else $error("component length beyond limit");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TLEN_W'(PATH_LIMIT))
        else $error("path length beyond limit");

    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_PUT) |-> (first_err_reg == STAT_OK && !start_bad_reg))
        else $error("remainder byte emitted after an error");

    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.is_status && out_free) |=>
        (at_first_reg && comp_len_reg == '0 && state_reg == S_IDLE))
        else $error("path state not cleared after status");
`endif

endmodule

// ===== rtl/core/path_sanitizer_splitter.sv =====
// Path sanitizer and splitter top level: config port, sequencer, output register.
// A byte inside a component is only taken and stored; a byte that ends a component is followed
// by the check: a finish step, then where needed either a mount match, candidate by candidate over the
// single byte comparator, or the emitted bytes (buffer read then load), each later component led by a '/' word.
// End of path adds the status word. Results leave through one output register.
// rst_n clears all path state and loads the default mount table; the buffer is not cleared.
`timescale 1ns / 1ps

module path_sanitizer_splitter
    import pss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         path_byte,
    input  logic               end_of_path,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_status,
    output logic [7:0]         rel_byte,
    output logic [1:0]         status,
    output logic signed [1:0]  mount_index,
    output logic               last
);

    cfg_t  cfg;
    emit_t emit;
    logic  out_free;

    logic        out_valid_reg;
    logic        is_status_reg;
    logic [7:0]  rel_byte_reg;
    logic [1:0]  status_reg;
    logic [1:0]  mount_index_reg;
    logic        last_reg;

    pss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .path_byte   (path_byte),
        .end_of_path (end_of_path),
        .cfg         (cfg),
        .out_free    (out_free),
        .emit        (emit)
    );

    // Load a new word when the register is empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit.valid)
        begin
            is_status_reg   <= emit.is_status;
            rel_byte_reg    <= emit.rel_byte;
            status_reg      <= emit.status;
            mount_index_reg <= emit.mount_index;
            last_reg        <= emit.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_status   = is_status_reg;
    assign rel_byte    = rel_byte_reg;
    assign status      = status_reg;
    assign mount_index = $signed(mount_index_reg);
    assign last        = last_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the path sanitizer and splitter.
`timescale 1ns / 1ps

module tb_top;
    import pss_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 45;

    typedef struct packed {
        logic               is_status;
        logic [7:0]         rel_byte;
        status_t            status;
        logic signed [1:0]  mount_index;
        logic               last;
    } path_word_t;

    typedef struct packed {
        status_t            st;
        logic signed [1:0]  mi;
    } status_note_t;

    typedef struct {
        string              head;
        string              body;
        int                 reps;
        string              tail;
        status_t            st;
        logic signed [1:0]  mi;
    } path_case_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         path_byte;
    logic               end_of_path;
    logic               out_valid;
    logic               out_ready;
    logic               is_status;
    logic [7:0]         rel_byte;
    logic [1:0]         status;
    logic signed [1:0]  mount_index;
    logic               last;

    // mount table as the block should hold it
    logic [63:0]        cfg_name [MOUNTS];
    logic [3:0]         cfg_len [MOUNTS];
    logic [1:0]         cfg_count;

    // path state of the normalizer
    logic [7:0]         comp_buf [NAME_LIMIT];
    int                 comp_len;
    int                 path_len;
    logic               first_byte;
    logic               lead_bad;
    status_t            first_err;
    logic [1:0]         mount_hit;
    logic               comp_bad;
    logic               rem_started;

    path_word_t         step_words [$];
    path_word_t         expected_words [$];
    status_note_t       status_notes [$];
    logic [7:0]         path_bytes [$];

    int                 mismatch_count = 0;
    int                 bytes_taken = 0;
    int                 hold_mark = 32'h7fffffff;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    path_case_t directed_paths [] = '{
        '{"/",                   "",         0,  "",     STAT_OK,       ROOT_IDX},
        '{"/int",                "",         0,  "",     STAT_OK,       2'sd0},
        '{"/sd//a/./b/",         "",         0,  "",     STAT_OK,       2'sd1},
        '{"abc",                 "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/etc",                "",         0,  "",     STAT_NOTFOUND, ROOT_IDX},
        '{"/int/a/../b",         "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/int/a\\b",           "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/int/\001x",          "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/int/a\037/\177",     "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/int/ \377\200~",     "",         0,  "",     STAT_OK,       2'sd0},
        '{"/int/",               "x",        31, "",     STAT_OK,       2'sd0},
        '{"/int/a/",             "x",        31, "",     STAT_OK,       2'sd0},
        '{"/int/",               "y",        32, "",     STAT_TOOBIG,   ROOT_IDX},
        '{"/int",                "/abcdefg", 16, "",     STAT_TOOBIG,   ROOT_IDX},
        '{"/int/abc",            "/abcdefg", 15, "",     STAT_TOOBIG,   ROOT_IDX},
        '{"/int/ab",             "/abcdefg", 15, "",     STAT_OK,       2'sd0},
        '{"x/int",               "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"\\int/a",             "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/.",                  "",         0,  "",     STAT_OK,       ROOT_IDX},
        '{"/..",                 "",         0,  "",     STAT_ARG,      ROOT_IDX},
        '{"/int/...",            "",         0,  "",     STAT_OK,       2'sd0},
        '{"/int/a\001/../",      "z",        40, "",     STAT_ARG,      ROOT_IDX},
        '{"/int/",               "z",        40, "/a\\", STAT_TOOBIG,   ROOT_IDX},
        '{"//int//x",            "",         0,  "",     STAT_OK,       2'sd0},
        '{"a",                   "/abcdefg", 17, "",     STAT_ARG,      ROOT_IDX}
    };

    path_sanitizer_splitter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .path_byte   (path_byte),
        .end_of_path (end_of_path),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_status   (is_status),
        .rel_byte    (rel_byte),
        .status      (status),
        .mount_index (mount_index),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_path();
        comp_len    = 0;
        path_len    = 0;
        first_byte  = 1'b1;
        lead_bad    = 1'b0;
        first_err   = STAT_OK;
        mount_hit   = NO_MOUNT;
        comp_bad    = 1'b0;
        rem_started = 1'b0;
    endfunction

    function automatic void push_word(logic flag, logic [7:0] b, status_t code,
                                      logic signed [1:0] mi);
        path_word_t w;
        w.is_status   = flag;
        w.rel_byte    = b;
        w.status      = code;
        w.mount_index = mi;
        w.last        = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic logic name_hit(int m);
        int n;
        n = (cfg_len[m] > MOUNT_NAME_BYTES) ? MOUNT_NAME_BYTES : int'(cfg_len[m]);
        if (n == 0 || comp_len != n)
            return 1'b0;
        for (int j = 0; j < n; j++)
        begin
            if (cfg_name[m][8*j +: 8] != comp_buf[j])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] lookup_mount();
        int used;
        used = (cfg_count > MOUNTS) ? MOUNTS : int'(cfg_count);
        for (int m = 0; m < used; m++)
        begin
            if (name_hit(m))
                return 2'(m);
        end
        return NO_MOUNT;
    endfunction

    function automatic void close_component();
        if (comp_len == 0)
            return;
        if (!lead_bad && first_err == STAT_OK)
        begin
            if (comp_len >= NAME_LIMIT)
                first_err = STAT_TOOBIG;
            else if (comp_bad)
                first_err = STAT_ARG;
            else if (comp_len == 1 && comp_buf[0] == CH_DOT)
            begin
                // drop single dot
            end
            else if (comp_len == 2 && comp_buf[0] == CH_DOT && comp_buf[1] == CH_DOT)
                first_err = STAT_ARG;
            else if (mount_hit == NO_MOUNT)
            begin
                mount_hit = lookup_mount();
                if (mount_hit == NO_MOUNT)
                    first_err = STAT_NOTFOUND;
            end
            else if (path_len < PATH_LIMIT)
            begin
                if (rem_started)
                    push_word(1'b0, CH_SLASH, STAT_OK, 2'sd0);
                for (int k = 0; k < comp_len; k++)
                    push_word(1'b0, comp_buf[k], STAT_OK, 2'sd0);
                rem_started = 1'b1;
            end
        end
        comp_len = 0;
        comp_bad = 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] ch, logic eop);
        path_word_t         w;
        status_t            code;
        logic signed [1:0]  mi;
        status_note_t       note;
        if (first_byte)
        begin
            if (ch != CH_SLASH)
                lead_bad = 1'b1;
            first_byte = 1'b0;
        end
        if (path_len < PATH_LIMIT)
            path_len++;
        if (ch == CH_SLASH)
            close_component();
        else
        begin
            if (ch < CH_SPACE || ch == CH_DEL || ch == CH_BSLASH)
                comp_bad = 1'b1;
            if (comp_len < NAME_LIMIT)
            begin
                comp_buf[comp_len] = ch;
                comp_len++;
            end
        end
        if (eop)
        begin
            close_component();
            if (lead_bad)
                code = STAT_ARG;
            else if (path_len >= PATH_LIMIT)
                code = STAT_TOOBIG;
            else
                code = first_err;
            mi = (code == STAT_OK && mount_hit != NO_MOUNT) ? mount_hit : ROOT_IDX;
            // directed paths carry their status as typed in the table
            if (status_notes.size() > 0)
            begin
                note = status_notes.pop_front();
                code = note.st;
                mi   = note.mi;
            end
            push_word(1'b1, 8'h00, code, mi);
            clear_path();
        end
        foreach (step_words[i])
        begin
            w = step_words[i];
            w.last = (i == step_words.size() - 1);
            expected_words.push_back(w);
        end
        step_words.delete();
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
    endtask

    task automatic check_word();
        path_word_t w;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word", {is_status, rel_byte, status}, 64'd0);
            return;
        end
        w = expected_words.pop_front();
        if (is_status !== w.is_status)
            report_mismatch("is_status", is_status, w.is_status);
        if (rel_byte !== w.rel_byte)
            report_mismatch("rel_byte", rel_byte, w.rel_byte);
        if (status !== w.status)
            report_mismatch("status", status, w.status);
        if (mount_index !== w.mount_index)
            report_mismatch("mount_index", mount_index, w.mount_index);
        if (last !== w.last)
            report_mismatch("last", last, w.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                bytes_taken++;
                predict_byte(path_byte, end_of_path);
            end
            if (out_valid && out_ready)
                check_word();
        end
    end

    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off to back up the block
    initial
    begin : receiver
        logic held;
        held = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && bytes_taken >= hold_mark)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 8);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MOUNT0_NAME: cfg_name[0] = val;
            REG_MOUNT0_LEN:  cfg_len[0]  = val[3:0];
            REG_MOUNT1_NAME: cfg_name[1] = val;
            REG_MOUNT1_LEN:  cfg_len[1]  = val[3:0];
            REG_MOUNT_COUNT: cfg_count   = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_mounts(logic [63:0] n0, logic [3:0] l0, logic [63:0] n1,
                              logic [3:0] l1, logic [1:0] used);
        write_reg(REG_MOUNT0_NAME, n0);
        write_reg(REG_MOUNT0_LEN, 64'(l0));
        write_reg(REG_MOUNT1_NAME, n1);
        write_reg(REG_MOUNT1_LEN, 64'(l1));
        write_reg(REG_MOUNT_COUNT, 64'(used));
    endtask

    task automatic send_byte(logic [7:0] b, logic eop);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        path_byte   <= b;
        end_of_path <= eop;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_path();
        foreach (path_bytes[i])
            send_byte(path_bytes[i], i == path_bytes.size() - 1);
    endtask

    // drain every pending word, then give a silent tail time to finish
    task automatic settle();
        in_valid <= 1'b0;
        wait (expected_words.size() == 0);
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'($urandom_range(128, 255));
        if (r == 1)
            return CH_SPACE;
        if (r == 2)
            return CH_DOT;
        if (r == 3)
            return 8'($urandom_range(33, 45));
        if (r == 4)
            return 8'($urandom_range(48, 91));
        return 8'($urandom_range(97, 122));
    endfunction

    function automatic logic [7:0] bad_char();
        case ($urandom_range(0, 2))
            0: return 8'($urandom_range(1, 31));
            1: return CH_DEL;
            default: return CH_BSLASH;
        endcase
    endfunction

    function automatic void add_component();
        int t;
        int n;
        int k;
        t = $urandom_range(0, 99);
        if (t < 8)
            path_bytes.push_back(CH_DOT);
        else if (t < 12)
        begin
            path_bytes.push_back(CH_DOT);
            path_bytes.push_back(CH_DOT);
        end
        else if (t < 18)
        begin
            n = $urandom_range(1, 6);
            k = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
                path_bytes.push_back((i == k) ? bad_char() : plain_char());
        end
        else
        begin
            // occasionally straddle the component length limit
            n = (t < 22) ? $urandom_range(NAME_LIMIT - 2, NAME_LIMIT + 1)
                         : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                path_bytes.push_back(plain_char());
        end
    endfunction

    function automatic void build_random_path();
        int r;
        int m;
        int n;
        logic [7:0] c;
        path_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            path_bytes.push_back(CH_SLASH);
            if ($urandom_range(0, 4) == 0)
                path_bytes.push_back(CH_SLASH);
            m = $urandom_range(0, 4);
            if (m < MOUNTS && cfg_len[m] != 0)
            begin
                n = (cfg_len[m] > MOUNT_NAME_BYTES) ? MOUNT_NAME_BYTES : int'(cfg_len[m]);
                for (int j = 0; j < n; j++)
                begin
                    c = cfg_name[m][8*j +: 8];
                    path_bytes.push_back((c == 8'h00) ? 8'h7a : c);
                end
            end
            else if (m < 4)
                add_component();
            if (m != 4)
            begin
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    path_bytes.push_back(CH_SLASH);
                    if ($urandom_range(0, 5) == 0)
                        path_bytes.push_back(CH_SLASH);
                    add_component();
                end
                if ($urandom_range(0, 3) == 0)
                    path_bytes.push_back(CH_SLASH);
            end
        end
        else if (r < 88)
        begin
            path_bytes.push_back(plain_char());
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++)
                path_bytes.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                path_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    task automatic run_random(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            build_random_path();
            send_path();
            sent += path_bytes.size();
        end
    endtask

    function automatic logic [63:0] random_name();
        logic [63:0] v;
        for (int j = 0; j < 8; j++)
            v[8*j +: 8] = 8'($urandom_range(97, 122));
        return v;
    endfunction

    initial
    begin : stimulus
        status_note_t note;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_valid    <= 1'b0;
        path_byte   <= 8'h00;
        end_of_path <= 1'b0;
        cfg_name[0] = 64'd7630441;
        cfg_len[0]  = 4'd3;
        cfg_name[1] = 64'd25715;
        cfg_len[1]  = 4'd2;
        cfg_count   = 2'd2;
        clear_path();
        send_idle_pct = 31;
        recv_idle_pct = 67;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_paths[c])
        begin
            path_bytes.delete();
            for (int i = 0; i < directed_paths[c].head.len(); i++)
                path_bytes.push_back(directed_paths[c].head[i]);
            for (int r = 0; r < directed_paths[c].reps; r++)
                for (int i = 0; i < directed_paths[c].body.len(); i++)
                    path_bytes.push_back(directed_paths[c].body[i]);
            for (int i = 0; i < directed_paths[c].tail.len(); i++)
                path_bytes.push_back(directed_paths[c].tail[i]);
            note.st = directed_paths[c].st;
            note.mi = directed_paths[c].mi;
            status_notes.push_back(note);
            send_path();
        end

        // "home" and "x", one entry in use
        settle();
        set_mounts(64'h656d6f68, 4'd4, 64'h78, 4'd1, 2'd1);
        run_random(PHASE_BYTES);

        // longest names, oversized length and count
        settle();
        send_idle_pct = 67;
        recv_idle_pct = 31;
        set_mounts(64'hffff_ffff_ffff_ffff, 4'd15, 64'h6867_6665_6463_6261, 4'd8, 2'd3);
        run_random(PHASE_BYTES);

        // zero-length first entry never matches
        settle();
        set_mounts(64'd7630441, 4'd0, random_name(), 4'($urandom_range(1, 8)), 2'd2);
        run_random(PHASE_BYTES);

        // empty table
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_mounts(64'd7630441, 4'd3, 64'd25715, 4'd2, 2'd0);
        run_random(PHASE_BYTES);

        // random names; hold the output to back up the block
        settle();
        set_mounts(random_name(), 4'($urandom_range(1, 8)), random_name(),
                   4'($urandom_range(1, 8)), 2'd2);
        hold_mark = bytes_taken + 4;
        run_random(PHASE_BYTES + 10);

        settle();
        if (expected_words.size() != 0)
            report_mismatch("words never received", expected_words.size(), 64'd0);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pss_pkg.sv
rtl/core/pss_cfg.sv
rtl/core/pss_cbuf.sv
rtl/core/pss_ctrl.sv
rtl/core/path_sanitizer_splitter.sv
tb/tb_top.sv
